FILE: src/rmnr_pkg.sv
// Shared types and constants for the running median and nadir radius filter.
package rmnr_pkg;

    localparam int DataW    = 16;
    localparam int CotW     = 16;
    localparam int CotFrac  = 12;
    localparam int RadW     = 20;
    localparam int FillOutW = 4;
    localparam int OutW     = 40;
    localparam int ApbAddrW = 3;
    localparam int ApbDataW = 32;

    localparam logic [CotW-1:0] CotReset = 16'd11896;

    // Register index taken from paddr[2].
    localparam logic RegNadirCot = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DROP,
        ST_INSERT,
        ST_MEDIAN,
        ST_OUTPUT
    } t_state;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_DROP,
        OP_INSERT
    } t_cell_op;

    // Broadcast from the controller to every cell of the chain.
    typedef struct packed {
        t_cell_op         op;
        logic [DataW-1:0] sample;
        logic [DataW-1:0] drop_value;
    } t_cell_bus;

endpackage

FILE: src/running_median_nadir_radius_top.sv
// A request passes through the drop (window full only), insert, median and output states, and
// no new one is taken until it leaves them; the drop, insert and median steps of the
// cell chain and the output multiply run one after another for each request.
// A new request is taken while the previous result still waits in the output register.
// Reset (synchronous, active low) empties the window, drops any pending result and sets the
// cotangent to cot 19 degrees; cell contents are not cleared.
module running_median_nadir_radius_top #(
    parameter int WINDOW_LENGTH = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [rmnr_pkg::DataW-1:0]     s_axis_tdata,  // [15:0] depth_sample
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [rmnr_pkg::OutW-1:0]      m_axis_tdata,  // [15:0] median_depth,
                                                          // [35:16] nadir_radius,
                                                          // [39:36] window_fill
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rmnr_pkg::ApbAddrW-1:0]  paddr,
    input  logic [rmnr_pkg::ApbDataW-1:0]  pwdata,
    output logic [rmnr_pkg::ApbDataW-1:0]  prdata,
    output logic                           pready
);

    localparam int FillW = $clog2(WINDOW_LENGTH + 1);
    localparam logic [FillW-1:0] FillMax = FillW'(WINDOW_LENGTH);

    rmnr_pkg::t_state                   r_state, n_state;
    logic [FillW-1:0]                   r_fill, n_fill;
    logic [rmnr_pkg::DataW-1:0]         r_sample;
    logic [rmnr_pkg::DataW-1:0]         r_med;
    logic [rmnr_pkg::CotW-1:0]          r_cot;
    logic                               r_out_valid, n_out_valid;
    logic [rmnr_pkg::OutW-1:0]          r_out_data;
    logic                               w_accept, w_load;
    logic [rmnr_pkg::DataW-1:0]         w_median;
    logic [rmnr_pkg::DataW+rmnr_pkg::CotW-1:0] w_product;
    logic [rmnr_pkg::RadW-1:0]          w_radius;

    // Configuration port
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cot <= rmnr_pkg::CotReset;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == rmnr_pkg::RegNadirCot)) begin
            r_cot <= pwdata[rmnr_pkg::CotW-1:0];
        end
    end

    always_comb begin
        unique case (paddr[2])
            rmnr_pkg::RegNadirCot: prdata = {{(rmnr_pkg::ApbDataW-rmnr_pkg::CotW){1'b0}}, r_cot};
            default:               prdata = '0;
        endcase
    end

    // Sequencer
    assign s_axis_tready = (r_state == rmnr_pkg::ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_load        = (r_state == rmnr_pkg::ST_OUTPUT) && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_out_valid = r_out_valid;
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            rmnr_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = (r_fill == FillMax) ? rmnr_pkg::ST_DROP : rmnr_pkg::ST_INSERT;
                end
            end
            rmnr_pkg::ST_DROP: begin
                n_fill  = r_fill - FillW'(1);
                n_state = rmnr_pkg::ST_INSERT;
            end
            rmnr_pkg::ST_INSERT: begin
                n_fill  = r_fill + FillW'(1);
                n_state = rmnr_pkg::ST_MEDIAN;
            end
            rmnr_pkg::ST_MEDIAN: begin
                n_state = rmnr_pkg::ST_OUTPUT;
            end
            rmnr_pkg::ST_OUTPUT: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_state     = rmnr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rmnr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rmnr_pkg::ST_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    rmnr_chain #(
        .WINDOW_LENGTH (WINDOW_LENGTH)
    ) u_chain (
        .i_clk    (i_clk),
        .i_state  (r_state),
        .i_sample (r_sample),
        .i_fill   (r_fill),
        .o_median (w_median)
    );

    assign w_product = r_med * r_cot;
    assign w_radius  = w_product[rmnr_pkg::CotFrac +: rmnr_pkg::RadW];

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= s_axis_tdata;
        end
        if (r_state == rmnr_pkg::ST_MEDIAN) begin
            r_med <= w_median;
        end
        if (w_load) begin
            r_out_data <= {rmnr_pkg::FillOutW'(r_fill), w_radius, r_med};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FillMax)
        else $error("window fill above its length");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rmnr_pkg::ST_DROP) |-> (r_fill == FillMax))
        else $error("drop step taken on a window that is not full");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == rmnr_pkg::ST_DROP || r_state == rmnr_pkg::ST_INSERT))
        else $error("accepted request did not start the chain update");

    a_result_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (r_fill != '0))
        else $error("result issued from an empty window");

endmodule

FILE: src/rmnr_cell.sv
// One cell of the sorted chain: a held sample and its age tag.
module rmnr_cell #(
    parameter int AgeW = 4,
    parameter logic [AgeW-1:0] AgeOld = '1
) (
    input  logic                        i_clk,
    input  rmnr_pkg::t_cell_bus         i_bus,
    input  logic                        i_valid,
    input  logic                        i_left_valid,
    input  logic                        i_left_gt,
    input  logic [rmnr_pkg::DataW-1:0]  i_left_value,
    input  logic [AgeW-1:0]             i_left_age,
    input  logic [rmnr_pkg::DataW-1:0]  i_right_value,
    input  logic [AgeW-1:0]             i_right_age,
    output logic [rmnr_pkg::DataW-1:0]  o_value,
    output logic [AgeW-1:0]             o_age,
    output logic                        o_gt,
    output logic                        o_oldest
);

    logic [rmnr_pkg::DataW-1:0] r_value, n_value;
    logic [AgeW-1:0]            r_age, n_age;
    logic                       w_take;

    assign o_gt     = i_valid && (r_value > i_bus.sample);
    assign o_oldest = i_valid && (r_age == AgeOld);
    assign w_take   = o_gt || (!i_valid && i_left_valid);

    always_comb begin
        n_value = r_value;
        n_age   = r_age;
        case (i_bus.op)
            rmnr_pkg::OP_DROP: begin
                // Within a run of equal values the oldest sits first, so every
                // cell at or above the dropped value closes the gap.
                if (i_valid && (r_value >= i_bus.drop_value)) begin
                    n_value = i_right_value;
                    n_age   = i_right_age;
                end
            end
            rmnr_pkg::OP_INSERT: begin
                if (w_take) begin
                    if (i_left_gt) begin
                        n_value = i_left_value;
                        n_age   = i_left_age + AgeW'(1);
                    end else begin
                        n_value = i_bus.sample;
                        n_age   = '0;
                    end
                end else if (i_valid) begin
                    n_age = r_age + AgeW'(1);
                end
            end
            default: begin
                n_value = r_value;
                n_age   = r_age;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_age   <= n_age;
    end

    assign o_value = r_value;
    assign o_age   = r_age;

endmodule

FILE: src/rmnr_chain.sv
// Row of sorted cells with the oldest-value broadcast and the median pick.
module rmnr_chain #(
    parameter int WINDOW_LENGTH = 10
) (
    input  logic                                   i_clk,
    input  rmnr_pkg::t_state                       i_state,
    input  logic [rmnr_pkg::DataW-1:0]             i_sample,
    input  logic [$clog2(WINDOW_LENGTH+1)-1:0]     i_fill,
    output logic [rmnr_pkg::DataW-1:0]             o_median
);

    localparam int FillW = $clog2(WINDOW_LENGTH + 1);
    localparam int AgeW  = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
    localparam logic [AgeW-1:0] AgeOld = AgeW'(WINDOW_LENGTH - 1);

    logic [rmnr_pkg::DataW-1:0] w_value  [WINDOW_LENGTH];
    logic [AgeW-1:0]            w_age    [WINDOW_LENGTH];
    logic                       w_gt     [WINDOW_LENGTH];
    logic                       w_oldest [WINDOW_LENGTH];
    logic                       w_valid  [WINDOW_LENGTH];
    rmnr_pkg::t_cell_bus        w_bus;
    logic [rmnr_pkg::DataW-1:0] w_drop_value;
    logic [FillW-1:0]           w_hi_idx, w_lo_idx;
    logic [rmnr_pkg::DataW-1:0] w_hi, w_lo;
    logic [rmnr_pkg::DataW:0]   w_sum;

    always_comb begin
        w_drop_value = '0;
        for (int i = 0; i < WINDOW_LENGTH; i++) begin
            w_valid[i] = (FillW'(i) < i_fill);
            if (w_oldest[i]) begin
                w_drop_value = w_drop_value | w_value[i];
            end
        end
    end

    always_comb begin
        w_bus.sample     = i_sample;
        w_bus.drop_value = w_drop_value;
        case (i_state)
            rmnr_pkg::ST_DROP:   w_bus.op = rmnr_pkg::OP_DROP;
            rmnr_pkg::ST_INSERT: w_bus.op = rmnr_pkg::OP_INSERT;
            default:             w_bus.op = rmnr_pkg::OP_HOLD;
        endcase
    end

    for (genvar g = 0; g < WINDOW_LENGTH; g++) begin : g_cell
        logic                       w_lv, w_lgt;
        logic [rmnr_pkg::DataW-1:0] w_lval, w_rval;
        logic [AgeW-1:0]            w_lage, w_rage;

        if (g == 0) begin : g_first
            assign w_lv   = 1'b1;
            assign w_lgt  = 1'b0;
            assign w_lval = '0;
            assign w_lage = '0;
        end else begin : g_inner
            assign w_lv   = w_valid[g-1];
            assign w_lgt  = w_gt[g-1];
            assign w_lval = w_value[g-1];
            assign w_lage = w_age[g-1];
        end

        if (g == WINDOW_LENGTH - 1) begin : g_last
            assign w_rval = '0;
            assign w_rage = '0;
        end else begin : g_mid
            assign w_rval = w_value[g+1];
            assign w_rage = w_age[g+1];
        end

        rmnr_cell #(
            .AgeW   (AgeW),
            .AgeOld (AgeOld)
        ) u_cell (
            .i_clk         (i_clk),
            .i_bus         (w_bus),
            .i_valid       (w_valid[g]),
            .i_left_valid  (w_lv),
            .i_left_gt     (w_lgt),
            .i_left_value  (w_lval),
            .i_left_age    (w_lage),
            .i_right_value (w_rval),
            .i_right_age   (w_rage),
            .o_value       (w_value[g]),
            .o_age         (w_age[g]),
            .o_gt          (w_gt[g]),
            .o_oldest      (w_oldest[g])
        );
    end

    // For an odd count both picks land on the middle cell.
    assign w_hi_idx = i_fill >> 1;
    assign w_lo_idx = i_fill[0] ? w_hi_idx : (w_hi_idx - FillW'(1));

    always_comb begin
        w_hi = '0;
        w_lo = '0;
        for (int i = 0; i < WINDOW_LENGTH; i++) begin
            if (FillW'(i) == w_hi_idx) begin
                w_hi = w_hi | w_value[i];
            end
            if (FillW'(i) == w_lo_idx) begin
                w_lo = w_lo | w_value[i];
            end
        end
    end

    assign w_sum    = {1'b0, w_hi} + {1'b0, w_lo};
    assign o_median = w_sum[rmnr_pkg::DataW:1];

endmodule
